@@ rtl/core/rmd_pkg.sv @@
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared widths, constants and arithmetic helpers of the rotation mismatch
// distance pipeline.
// ----------------------------------------------------------------------------
package rmd_pkg;

	// cordic configuration
	localparam int CORDIC_STEPS = 16;
	localparam int SAMPLE_WIDTH = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

	// datapath widths
	localparam int Z_W    = 36;                 // angle accumulator, q30
	localparam int XY_W   = SAMPLE_WIDTH + 3;   // cordic x and y
	localparam int XYE_W  = XY_W + 1;
	localparam int TRIG_W = 34;                 // sine and cosine, q30
	localparam int E_W    = TRIG_W + 1;         // euler entry
	localparam int Q_W    = 36;                 // quaternion entry, q30
	localparam int DF_W   = 38;                 // raw difference
	localparam int D_W    = 28;                 // difference, q20
	localparam int SUM_W  = 2 * D_W;            // sum of squares, q40
	localparam int ISQ_STEPS = SUM_W / 2;
	localparam int ROOT_W = SUM_W / 2;

	// pipeline latencies
	localparam int CORD_LAT = STEPS + 2;
	localparam int NSTAGE   = CORD_LAT + 7 + ISQ_STEPS;

	// q30 angle constants
	localparam logic signed [Z_W-1:0] Q30_PI      = Z_W'(64'sd3373259426);
	localparam logic signed [Z_W-1:0] Q30_HALF_PI = Z_W'(64'sd1686629713);
	localparam logic signed [Z_W-1:0] Q30_TWO_PI  = Z_W'(64'sd6746518852);
	localparam logic signed [Q_W-1:0] Q30_ONE     = Q_W'(64'sd1073741824);

	// cordic start value, gain compensated
	localparam int GAIN_SHIFT = 32 - SAMPLE_WIDTH;
	localparam logic [63:0] GAIN_Q32 = 64'd2608131496;
	localparam logic [63:0] X_INIT_64 = (GAIN_SHIFT > 0) ?
		((GAIN_Q32 + (64'd1 << ((GAIN_SHIFT > 0) ? GAIN_SHIFT - 1 : 0))) >> GAIN_SHIFT) :
		GAIN_Q32;
	localparam logic signed [XY_W-1:0] X_INIT = XY_W'(X_INIT_64);

	// rescale of cordic output to q30
	localparam int L_SH = (SAMPLE_WIDTH <= 30) ? 30 - SAMPLE_WIDTH : 0;
	localparam int R_SH = (SAMPLE_WIDTH > 30) ? SAMPLE_WIDTH - 30 : 0;
	localparam logic signed [XYE_W-1:0] RND_Q = (R_SH > 0) ?
		XYE_W'(64'd1 << ((R_SH > 0) ? R_SH - 1 : 0)) : '0;

	localparam logic signed [2*TRIG_W-1:0] MUL_RND = (2*TRIG_W)'(64'sd536870912);

	// arctangent table, q30
	function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
		logic [31:0] v;
		case (idx)
			0:  v = 32'h3243F6A8;
			1:  v = 32'h1DAC6705;
			2:  v = 32'h0FADBAFC;
			3:  v = 32'h07F56EA6;
			4:  v = 32'h03FEAB76;
			5:  v = 32'h01FFD55B;
			6:  v = 32'h00FFFAAA;
			7:  v = 32'h007FFF55;
			8:  v = 32'h003FFFEA;
			9:  v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			default: v = 32'h0;
		endcase
		return signed'({{(Z_W-32){1'b0}}, v});
	endfunction

	// cordic sample to q30, rounding half up when narrowing
	function automatic logic signed [TRIG_W-1:0] to_q30(input logic signed [XY_W-1:0] v);
		logic signed [XYE_W-1:0] t;
		t = XYE_W'(v) + RND_Q;
		if (R_SH > 0)
			return TRIG_W'(t >>> R_SH);
		return TRIG_W'(v) <<< L_SH;
	endfunction

	// q30 product, rounded
	function automatic logic signed [TRIG_W-1:0] mul_q30(input logic signed [TRIG_W-1:0] a,
		input logic signed [TRIG_W-1:0] b);
		logic signed [2*TRIG_W-1:0] p;
		p = a * b + MUL_RND;
		return TRIG_W'(p >>> 30);
	endfunction

endpackage

@@ rtl/core/rmd_cordic.sv @@
// ----------------------------------------------------------------------------
// rmd_cordic
// Pipelined sine and cosine of one q4.12 angle: range fold, one cordic
// iteration per stage, output rescaled to q30.
// ----------------------------------------------------------------------------
module rmd_cordic
	import rmd_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [15:0]       angle,
	output logic signed [TRIG_W-1:0] sin_q30,
	output logic signed [TRIG_W-1:0] cos_q30
);

	logic signed [XY_W-1:0] x_q [0:STEPS];
	logic signed [XY_W-1:0] y_q [0:STEPS];
	logic signed [Z_W-1:0]  z_q [0:STEPS];
	logic                   neg_q [0:STEPS];

	logic signed [Z_W-1:0] z_raw, z_wrap, z_fold;
	logic                  neg_fold;

	// wrap into [-pi, pi] and fold into [-pi/2, pi/2]
	always_comb begin
		z_raw = Z_W'(angle) <<< 18;
		if (z_raw > Q30_PI)
			z_wrap = z_raw - Q30_TWO_PI;
		else if (z_raw < -Q30_PI)
			z_wrap = z_raw + Q30_TWO_PI;
		else
			z_wrap = z_raw;
		neg_fold = 1'b0;
		z_fold = z_wrap;
		if (z_wrap > Q30_HALF_PI) begin
			z_fold = z_wrap - Q30_PI;
			neg_fold = 1'b1;
		end else if (z_wrap < -Q30_HALF_PI) begin
			z_fold = z_wrap + Q30_PI;
			neg_fold = 1'b1;
		end
	end

	// prep stage
	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= X_INIT;
			y_q[0] <= '0;
			z_q[0] <= z_fold;
			neg_q[0] <= neg_fold;
		end
	end

	// one rotation per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				neg_q[i+1] <= neg_q[i];
				if (z_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_q30(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_q30(i);
				end
			end
		end
	end

	// unfold sign and rescale
	always_ff @(posedge clk) begin
		if (en) begin
			cos_q30 <= to_q30(neg_q[STEPS] ? -x_q[STEPS] : x_q[STEPS]);
			sin_q30 <= to_q30(neg_q[STEPS] ? -y_q[STEPS] : y_q[STEPS]);
		end
	end

endmodule

@@ rtl/core/rmd_isqrt.sv @@
// ----------------------------------------------------------------------------
// rmd_isqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmd_isqrt
	import rmd_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [SUM_W-1:0]  radicand,
	output logic [ROOT_W-1:0] root
);

	logic [SUM_W-1:0] v_q [0:ISQ_STEPS-1];
	logic [SUM_W-1:0] r_q [0:ISQ_STEPS-1];

	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_bit
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
		logic [SUM_W-1:0] v_in, r_in, t;

		// previous remainder and partial root
		if (k == 0) begin : g_first
			assign v_in = radicand;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_q[k-1];
			assign r_in = r_q[k-1];
		end

		assign t = r_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in >= t) begin
					v_q[k] <= v_in - t;
					r_q[k] <= (r_in >> 1) + BIT;
				end else begin
					v_q[k] <= v_in;
					r_q[k] <= r_in >> 1;
				end
			end
		end
	end

	assign root = r_q[ISQ_STEPS-1][ROOT_W-1:0];

endmodule

@@ rtl/core/rotation_mismatch_distance.sv @@
// ----------------------------------------------------------------------------
// rotation_mismatch_distance
// Frobenius distance between a quaternion rotation matrix and a Z-Y-X Euler
// rotation matrix, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one request: quaternion (q2.14) and three angles
//   (q4.12 radians). m_* channel returns the distance (q4.12, saturated) in
//   m_tdata and the alternate-matrix flag in m_tuser.
//   cfg_* writes branch_threshold (q2.14); cfg_ready is always high. Write it
//   only while no request is in flight.
// Stages: cordic stages, two product stages, difference, squares, two adder
//   stages, one stage per root bit (28), and the output register, from
//   acceptance to m_tvalid.
// Throughput: one request per cycle unless stalled; stages move together.
// Reset: clears all valid bits and loads branch_threshold with 819.
// Stall: while m_tvalid is high and m_tready low, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated. Bubbles are carried as
//   cleared valid bits.
// ----------------------------------------------------------------------------
module rotation_mismatch_distance
	import rmd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [14:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// quat_w, quat_x, quat_y, quat_z, angle_z, angle_y, angle_x (16 bits each)
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// distance
	output logic [15:0]  m_tdata,
	// alternate_used
	output logic         m_tuser
);

	localparam int QL = CORD_LAT + 1;

	logic               en;
	logic [NSTAGE-1:0]  vld_q;
	logic               alt_q [0:NSTAGE-1];
	logic [14:0]        thr_q;

	logic signed [15:0] qw, qx, qy, qz;
	logic signed [TRIG_W-1:0] s0, c0, s1, c1, s2, c2;

	// global advance
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd819;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTAGE-2:0], s_tvalid};
		end
	end
	assign m_tvalid = vld_q[NSTAGE-1];

	assign qw = signed'(s_tdata[15:0]);
	assign qx = signed'(s_tdata[31:16]);
	assign qy = signed'(s_tdata[47:32]);
	assign qz = signed'(s_tdata[63:48]);

	// sines and cosines
	rmd_cordic u_cord_z (.clk(clk), .en(en), .angle(signed'(s_tdata[79:64])),
		.sin_q30(s0), .cos_q30(c0));
	rmd_cordic u_cord_y (.clk(clk), .en(en), .angle(signed'(s_tdata[95:80])),
		.sin_q30(s1), .cos_q30(c1));
	rmd_cordic u_cord_x (.clk(clk), .en(en), .angle(signed'(s_tdata[111:96])),
		.sin_q30(s2), .cos_q30(c2));

	// branch test
	logic [16:0] w_abs, y_abs;
	logic [17:0] y_lim;
	always_comb begin
		w_abs = qw[15] ? 17'(-{qw[15], qw}) : 17'({qw[15], qw});
		y_abs = qy[15] ? 17'(-{qy[15], qy}) : 17'({qy[15], qy});
		y_lim = 18'(y_abs) + 18'(thr_q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alt_q[0] <= !(18'(w_abs) > y_lim);
			for (int k = 1; k < NSTAGE; k++)
				alt_q[k] <= alt_q[k-1];
		end
	end

	// quaternion products
	logic signed [31:0] p_xx_s0, p_yy_s0, p_zz_s0, p_xy_s0, p_xz_s0, p_yz_s0;
	logic signed [31:0] p_wx_s0, p_wy_s0, p_wz_s0;
	always_ff @(posedge clk) begin
		if (en) begin
			p_xx_s0 <= qx * qx;
			p_yy_s0 <= qy * qy;
			p_zz_s0 <= qz * qz;
			p_xy_s0 <= qx * qy;
			p_xz_s0 <= qx * qz;
			p_yz_s0 <= qy * qz;
			p_wx_s0 <= qw * qx;
			p_wy_s0 <= qw * qy;
			p_wz_s0 <= qw * qz;
		end
	end

	// quaternion matrix and its delay line
	logic signed [Q_W-1:0] qd_q [1:QL][9];
	always_ff @(posedge clk) begin
		if (en) begin
			qd_q[1][0] <= Q30_ONE - ((Q_W'(p_yy_s0) + Q_W'(p_zz_s0)) <<< 3);
			qd_q[1][1] <= (Q_W'(p_xy_s0) - Q_W'(p_wz_s0)) <<< 3;
			qd_q[1][2] <= (Q_W'(p_xz_s0) + Q_W'(p_wy_s0)) <<< 3;
			qd_q[1][3] <= (Q_W'(p_xy_s0) + Q_W'(p_wz_s0)) <<< 3;
			qd_q[1][4] <= Q30_ONE - ((Q_W'(p_xx_s0) + Q_W'(p_zz_s0)) <<< 3);
			qd_q[1][5] <= (Q_W'(p_yz_s0) - Q_W'(p_wx_s0)) <<< 3;
			qd_q[1][6] <= (Q_W'(p_xz_s0) - Q_W'(p_wy_s0)) <<< 3;
			qd_q[1][7] <= (Q_W'(p_yz_s0) + Q_W'(p_wx_s0)) <<< 3;
			qd_q[1][8] <= Q30_ONE - ((Q_W'(p_xx_s0) + Q_W'(p_yy_s0)) <<< 3);
			for (int k = 2; k <= QL; k++)
				qd_q[k] <= qd_q[k-1];
		end
	end

	// first product level
	logic signed [TRIG_W-1:0] c0c1_s1, s0c2_s1, s2s0_s1, s0c1_s1, c0c2_s1, c0s2_s1;
	logic signed [TRIG_W-1:0] c1s2_s1, c1c2_s1, c0s1_s1, s0s1_s1, s1_s1, s2_s1, c2_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			c0c1_s1 <= mul_q30(c0, c1);
			s0c2_s1 <= mul_q30(s0, c2);
			s2s0_s1 <= mul_q30(s2, s0);
			s0c1_s1 <= mul_q30(s0, c1);
			c0c2_s1 <= mul_q30(c0, c2);
			c0s2_s1 <= mul_q30(c0, s2);
			c1s2_s1 <= mul_q30(c1, s2);
			c1c2_s1 <= mul_q30(c1, c2);
			c0s1_s1 <= mul_q30(c0, s1);
			s0s1_s1 <= mul_q30(s0, s1);
			s1_s1 <= s1;
			s2_s1 <= s2;
			c2_s1 <= c2;
		end
	end

	// second product level
	logic signed [TRIG_W-1:0] c0c1_s2, s0c2_s2, s2s0_s2, s0c1_s2, c0c2_s2, c0s2_s2;
	logic signed [TRIG_W-1:0] c1s2_s2, c1c2_s2, s1_s2;
	logic signed [TRIG_W-1:0] c0s1s2_s2, c0s1c2_s2, s0s1s2_s2, s0s1c2_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			c0s1s2_s2 <= mul_q30(c0s1_s1, s2_s1);
			c0s1c2_s2 <= mul_q30(c0s1_s1, c2_s1);
			s0s1s2_s2 <= mul_q30(s0s1_s1, s2_s1);
			s0s1c2_s2 <= mul_q30(s0s1_s1, c2_s1);
			c0c1_s2 <= c0c1_s1;
			s0c2_s2 <= s0c2_s1;
			s2s0_s2 <= s2s0_s1;
			s0c1_s2 <= s0c1_s1;
			c0c2_s2 <= c0c2_s1;
			c0s2_s2 <= c0s2_s1;
			c1s2_s2 <= c1s2_s1;
			c1c2_s2 <= c1c2_s1;
			s1_s2 <= s1_s1;
		end
	end

	// euler entries, alternate signs and rounded differences
	logic signed [E_W-1:0]  e_mat [9];
	logic signed [DF_W-1:0] df [9];
	logic                   alt_s2;
	assign alt_s2 = alt_q[CORD_LAT+1];
	always_comb begin
		e_mat[0] = E_W'(c0c1_s2);
		e_mat[1] = E_W'(c0s1s2_s2) - E_W'(s0c2_s2);
		e_mat[2] = E_W'(s2s0_s2) + E_W'(c0s1c2_s2);
		e_mat[3] = E_W'(s0c1_s2);
		e_mat[4] = E_W'(c0c2_s2) + E_W'(s0s1s2_s2);
		e_mat[5] = E_W'(s0s1c2_s2) - E_W'(c0s2_s2);
		e_mat[6] = -E_W'(s1_s2);
		e_mat[7] = E_W'(c1s2_s2);
		e_mat[8] = E_W'(c1c2_s2);
		if (alt_s2) begin
			e_mat[0] = -e_mat[0];
			e_mat[3] = -e_mat[3];
			e_mat[7] = -e_mat[7];
			e_mat[8] = -e_mat[8];
		end
		for (int k = 0; k < 9; k++)
			df[k] = DF_W'(e_mat[k]) - DF_W'(qd_q[QL][k]) + DF_W'(512);
	end

	logic signed [D_W-1:0] d_s3 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++)
				d_s3[k] <= D_W'(df[k] >>> 10);
		end
	end

	// squares
	logic [SUM_W-1:0] sq_s4 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++)
				sq_s4[k] <= unsigned'(SUM_W'(d_s3[k]) * SUM_W'(d_s3[k]));
		end
	end

	// adder tree
	logic [SUM_W-1:0] ps_s5 [3];
	logic [SUM_W-1:0] sum_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++)
				ps_s5[k] <= sq_s4[3*k] + sq_s4[3*k+1] + sq_s4[3*k+2];
			sum_s6 <= ps_s5[0] + ps_s5[1] + ps_s5[2];
		end
	end

	// square root
	logic [ROOT_W-1:0] root;
	rmd_isqrt u_isqrt (.clk(clk), .en(en), .radicand(sum_s6), .root(root));

	// round to q12 and saturate
	logic [ROOT_W-8:0] dist_full;
	logic [15:0]       dist_q;
	assign dist_full = (ROOT_W-7)'((ROOT_W'(root) + ROOT_W'(128)) >> 8);
	always_ff @(posedge clk) begin
		if (en) begin
			dist_q <= (dist_full > (ROOT_W-7)'(16'hFFFF)) ? 16'hFFFF : dist_full[15:0];
		end
	end

	assign m_tdata = dist_q;
	assign m_tuser = alt_q[NSTAGE-1];

	// pipeline holds while the output stalls
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved during a stall");

	// valid bits advance one stage when enabled
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> vld_q[NSTAGE-1:1] == $past(vld_q[NSTAGE-2:0]))
		else $error("valid bits did not advance");

	// an accepted request enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted request lost at entry");

endmodule
